FILE: rtl/core/aarm_pkg.sv
`default_nettype none

package aarm_pkg;

  localparam int CORDIC_ITERS = 20;
  localparam int SQRT_STAGES  = 32;
  localparam int DIV_STAGES   = 31;
  localparam int NORM_LAT     = 2 + SQRT_STAGES + DIV_STAGES;
  localparam int ANG_LAT      = 3 + CORDIC_ITERS + 1;
  localparam int ANG_PAD      = NORM_LAT - ANG_LAT;
  localparam int MAT_LAT      = 4;
  localparam int TOTAL_LAT    = NORM_LAT + MAT_LAT;

  localparam int FULL_TURN    = 92160;
  localparam int HALF_TURN    = 46080;
  localparam int QUARTER_TURN = 23040;
  localparam int ONE_Q30      = 1073741824;
  localparam int GAIN_INV     = 652032874;

  // floor(2^40 / FULL_TURN)
  localparam logic signed [24:0] ANG_RECIP = 25'sd11930464;

  typedef struct packed {
    logic [2:0][15:0] mag;
    logic [2:0]       neg;
    logic             zero;
  } norm_side_t;

  function automatic logic [21:0] atan_q16(input logic [4:0] idx);
    logic [21:0] v;
    unique case (idx)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/aarm_angle.sv
`default_nettype none

module aarm_angle (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [23:0] ang_i,
  output logic signed [31:0] sin_o,
  output logic signed [32:0] omc_o
);

  localparam int NI = aarm_pkg::CORDIC_ITERS;
  localparam int NP = aarm_pkg::ANG_PAD;

  logic signed [23:0] ang1_q;
  logic signed [48:0] prod1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ang1_q  <= ang_i;
      prod1_q <= ang_i * aarm_pkg::ANG_RECIP;
    end
  end

  // remainder, corrected into [0, full turn)
  logic signed [7:0]  q2;
  logic signed [25:0] r2_raw;
  logic signed [17:0] r2_d, r2_q;

  always_comb begin
    q2     = prod1_q[47:40];
    r2_raw = 26'(ang1_q) - 26'(q2) * 26'(aarm_pkg::FULL_TURN);
    priority if (r2_raw < 26'sd0) begin
      r2_d = 18'(r2_raw + 26'(aarm_pkg::FULL_TURN));
    end else if (r2_raw >= 26'(aarm_pkg::FULL_TURN)) begin
      r2_d = 18'(r2_raw - 26'(aarm_pkg::FULL_TURN));
    end else begin
      r2_d = 18'(r2_raw);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) r2_q <= r2_d;
  end

  // fold into [-90, 90] degrees
  logic signed [17:0] r3a, r3b;
  logic               flip3;

  always_comb begin
    r3a = (r2_q > 18'(aarm_pkg::HALF_TURN)) ? r2_q - 18'(aarm_pkg::FULL_TURN) : r2_q;
    priority if (r3a > 18'(aarm_pkg::QUARTER_TURN)) begin
      r3b   = r3a - 18'(aarm_pkg::HALF_TURN);
      flip3 = 1'b1;
    end else if (r3a < -18'(aarm_pkg::QUARTER_TURN)) begin
      r3b   = r3a + 18'(aarm_pkg::HALF_TURN);
      flip3 = 1'b1;
    end else begin
      r3b   = r3a;
      flip3 = 1'b0;
    end
  end

  logic signed [32:0] cx_q [0:NI];
  logic signed [32:0] cy_q [0:NI];
  logic signed [25:0] cz_q [0:NI];
  logic               cf_q [0:NI];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cx_q[0] <= 33'(aarm_pkg::GAIN_INV);
      cy_q[0] <= 33'sd0;
      cz_q[0] <= 26'(r3b) * 26'sd256;
      cf_q[0] <= flip3;
    end
  end

  for (genvar i = 0; i < NI; i++) begin : g_cordic
    logic signed [25:0] at;
    assign at = $signed(26'(aarm_pkg::atan_q16(5'(i))));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (cz_q[i] >= 26'sd0) begin
          cx_q[i+1] <= cx_q[i] - (cy_q[i] >>> i);
          cy_q[i+1] <= cy_q[i] + (cx_q[i] >>> i);
          cz_q[i+1] <= cz_q[i] - at;
        end else begin
          cx_q[i+1] <= cx_q[i] + (cy_q[i] >>> i);
          cy_q[i+1] <= cy_q[i] - (cx_q[i] >>> i);
          cz_q[i+1] <= cz_q[i] + at;
        end
        cf_q[i+1] <= cf_q[i];
      end
    end
  end

  logic signed [32:0] cos_c, sin_c;
  logic signed [31:0] sp_q [0:NP];
  logic signed [32:0] tp_q [0:NP];

  assign cos_c = cf_q[NI] ? -cx_q[NI] : cx_q[NI];
  assign sin_c = cf_q[NI] ? -cy_q[NI] : cy_q[NI];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sp_q[0] <= 32'(sin_c);
      tp_q[0] <= 33'(aarm_pkg::ONE_Q30) - cos_c;
    end
  end

  for (genvar k = 0; k < NP; k++) begin : g_pad
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sp_q[k+1] <= sp_q[k];
        tp_q[k+1] <= tp_q[k];
      end
    end
  end

  assign sin_o = sp_q[NP];
  assign omc_o = tp_q[NP];

endmodule

`default_nettype wire

FILE: rtl/core/aarm_norm.sv
`default_nettype none

module aarm_norm (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [15:0] ax_i,
  input  logic signed [15:0] ay_i,
  input  logic signed [15:0] az_i,
  output logic signed [31:0] ux_o,
  output logic signed [31:0] uy_o,
  output logic signed [31:0] uz_o,
  output logic               zero_o
);

  localparam int NS = aarm_pkg::SQRT_STAGES;
  localparam int ND = aarm_pkg::DIV_STAGES;

  logic signed [15:0]     ain [3];
  logic [2:0][15:0]       mag_c;
  logic [2:0]             neg_c;
  logic [2:0][30:0]       sq_q;
  aarm_pkg::norm_side_t   s1_q;

  assign ain[0] = ax_i;
  assign ain[1] = ay_i;
  assign ain[2] = az_i;

  for (genvar l = 0; l < 3; l++) begin : g_abs
    logic signed [16:0] a17;
    assign a17      = 17'(ain[l]);
    assign neg_c[l] = ain[l][15];
    assign mag_c[l] = neg_c[l] ? 16'(-a17) : 16'(a17);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < 3; l++) sq_q[l] <= 31'(32'(mag_c[l]) * 32'(mag_c[l]));
      s1_q.mag  <= mag_c;
      s1_q.neg  <= neg_c;
      s1_q.zero <= (ax_i == 16'sd0) && (ay_i == 16'sd0) && (az_i == 16'sd0);
    end
  end

  // bit-serial square root of n2 * 2^32, one result bit per stage
  logic [63:0]          op_q [0:NS];
  logic [63:0]          rs_q [0:NS];
  aarm_pkg::norm_side_t ss_q [0:NS];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op_q[0] <= {32'(32'(sq_q[0]) + 32'(sq_q[1]) + 32'(sq_q[2])), 32'd0};
      rs_q[0] <= 64'd0;
      ss_q[0] <= s1_q;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    localparam logic [63:0] ONE = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;
    assign trial = rs_q[k] + ONE;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (op_q[k] >= trial) begin
          op_q[k+1] <= op_q[k] - trial;
          rs_q[k+1] <= (rs_q[k] >> 1) + ONE;
        end else begin
          op_q[k+1] <= op_q[k];
          rs_q[k+1] <= rs_q[k] >> 1;
        end
        ss_q[k+1] <= ss_q[k];
      end
    end
  end

  // three restoring dividers, |v| * 2^46 / root, one quotient bit per stage
  logic [32:0]          rin  [0:ND-1][3];
  logic [30:0]          qin  [0:ND-1][3];
  logic [31:0]          din  [0:ND-1];
  aarm_pkg::norm_side_t sin  [0:ND-1];
  logic [32:0]          rem_q [0:ND-1][3];
  logic [30:0]          quo_q [0:ND-1][3];
  logic [31:0]          dv_q  [0:ND-1];
  aarm_pkg::norm_side_t sd_q  [0:ND-1];

  assign din[0] = rs_q[NS][31:0];
  assign sin[0] = ss_q[NS];
  for (genvar l = 0; l < 3; l++) begin : g_dinit
    assign rin[0][l] = 33'(ss_q[NS].mag[l]) << 15;
    assign qin[0][l] = 31'd0;
  end

  for (genvar k = 1; k < ND; k++) begin : g_dlink
    assign din[k] = dv_q[k-1];
    assign sin[k] = sd_q[k-1];
    for (genvar l = 0; l < 3; l++) begin : g_lane
      assign rin[k][l] = rem_q[k-1][l];
      assign qin[k][l] = quo_q[k-1][l];
    end
  end

  for (genvar k = 0; k < ND; k++) begin : g_div
    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [33:0] sh;
      logic        ge;
      assign sh = {rin[k][l], 1'b0};
      assign ge = sh >= 34'(din[k]);
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k][l] <= ge ? 33'(sh - 34'(din[k])) : 33'(sh);
          quo_q[k][l] <= {qin[k][l][29:0], ge};
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_q[k] <= din[k];
        sd_q[k] <= sin[k];
      end
    end
  end

  logic signed [31:0] u_c [3];
  for (genvar l = 0; l < 3; l++) begin : g_sign
    assign u_c[l] = sd_q[ND-1].neg[l] ? -$signed(32'(quo_q[ND-1][l]))
                                      : $signed(32'(quo_q[ND-1][l]));
  end

  assign ux_o   = u_c[0];
  assign uy_o   = u_c[1];
  assign uz_o   = u_c[2];
  assign zero_o = sd_q[ND-1].zero;

endmodule

`default_nettype wire

FILE: rtl/core/aarm_matrix.sv
`default_nettype none

module aarm_matrix #(
  parameter int unsigned OUT_FRAC_BITS = 14
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] ux_i,
  input  logic signed [31:0] uy_i,
  input  logic signed [31:0] uz_i,
  input  logic signed [31:0] sin_i,
  input  logic signed [32:0] omc_i,
  input  logic               zero_i,
  output logic [8:0][15:0]   m_o,
  output logic               zero_o
);

  localparam int SH = 30 - int'(OUT_FRAC_BITS);
  localparam logic signed [37:0] HALF = 38'((64'd1 << SH) >> 1);
  localparam logic signed [37:0] LIM  = 38'(64'd1 << OUT_FRAC_BITS);

  function automatic logic signed [33:0] qm(input logic signed [31:0] a,
                                            input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p[63:30];
  endfunction

  function automatic logic signed [35:0] qt(input logic signed [32:0] t,
                                            input logic signed [34:0] a);
    logic signed [67:0] p;
    p = 68'(t) * 68'(a);
    return p[65:30];
  endfunction

  function automatic logic [15:0] rnd(input logic signed [36:0] v);
    logic signed [37:0] r;
    r = (38'(v) + HALF) >>> SH;
    if (r > LIM) r = LIM;
    else if (r < -LIM) r = -LIM;
    return r[15:0];
  endfunction

  // M1: axis products and sin-scaled axis
  logic signed [33:0] xx1_q, yy1_q, zz1_q, xy1_q, xz1_q, yz1_q, sx1_q, sy1_q, sz1_q;
  logic signed [32:0] t1_q;
  logic               z1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xx1_q <= qm(ux_i, ux_i);
      yy1_q <= qm(uy_i, uy_i);
      zz1_q <= qm(uz_i, uz_i);
      xy1_q <= qm(ux_i, uy_i);
      xz1_q <= qm(ux_i, uz_i);
      yz1_q <= qm(uy_i, uz_i);
      sx1_q <= qm(sin_i, ux_i);
      sy1_q <= qm(sin_i, uy_i);
      sz1_q <= qm(sin_i, uz_i);
      t1_q  <= omc_i;
      z1_q  <= zero_i;
    end
  end

  // M2: diagonal sums
  logic signed [34:0] a0_q, a1_q, a2_q, xy2_q, xz2_q, yz2_q;
  logic signed [33:0] sx2_q, sy2_q, sz2_q;
  logic signed [32:0] t2_q;
  logic               z2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a0_q  <= 35'(yy1_q) + 35'(zz1_q);
      a1_q  <= 35'(xx1_q) + 35'(zz1_q);
      a2_q  <= 35'(xx1_q) + 35'(yy1_q);
      xy2_q <= 35'(xy1_q);
      xz2_q <= 35'(xz1_q);
      yz2_q <= 35'(yz1_q);
      sx2_q <= sx1_q;
      sy2_q <= sy1_q;
      sz2_q <= sz1_q;
      t2_q  <= t1_q;
      z2_q  <= z1_q;
    end
  end

  // M3: (1 - cos) scaling
  logic signed [35:0] p0_q, p1_q, p2_q, pxy_q, pxz_q, pyz_q;
  logic signed [33:0] sx3_q, sy3_q, sz3_q;
  logic               z3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_q  <= qt(t2_q, a0_q);
      p1_q  <= qt(t2_q, a1_q);
      p2_q  <= qt(t2_q, a2_q);
      pxy_q <= qt(t2_q, xy2_q);
      pxz_q <= qt(t2_q, xz2_q);
      pyz_q <= qt(t2_q, yz2_q);
      sx3_q <= sx2_q;
      sy3_q <= sy2_q;
      sz3_q <= sz2_q;
      z3_q  <= z2_q;
    end
  end

  // M4: combine (identity for a zero axis), round, saturate
  logic signed [36:0] m_c [9];
  logic signed [36:0] one37;

  assign one37 = 37'(aarm_pkg::ONE_Q30);

  always_comb begin
    m_c[0] = one37 - 37'(p0_q);
    m_c[1] = 37'(pxy_q) - 37'(sz3_q);
    m_c[2] = 37'(pxz_q) + 37'(sy3_q);
    m_c[3] = 37'(pxy_q) + 37'(sz3_q);
    m_c[4] = one37 - 37'(p1_q);
    m_c[5] = 37'(pyz_q) - 37'(sx3_q);
    m_c[6] = 37'(pxz_q) - 37'(sy3_q);
    m_c[7] = 37'(pyz_q) + 37'(sx3_q);
    m_c[8] = one37 - 37'(p2_q);
    if (z3_q) begin
      for (int i = 0; i < 9; i++) m_c[i] = (i % 4 == 0) ? one37 : 37'sd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 9; i++) m_o[i] <= rnd(m_c[i]);
      zero_o <= z3_q;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/axis_angle_rotation_matrix_top.sv
// Throughput: one word per cycle while the output is not stalled; the per-bit
// square root and divider stages and the per-iteration CORDIC stages are each
// one register stage, all in one pipeline.
// A stalled output holds the whole pipeline, so no word is lost or repeated.
// Reset clears only the valid bits; payload registers are not reset.
`default_nettype none

module axis_angle_rotation_matrix_top #(
  parameter int unsigned OUT_FRAC_BITS = 14
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               stall_o,
  input  logic signed [15:0] axis_x_i,
  input  logic signed [15:0] axis_y_i,
  input  logic signed [15:0] axis_z_i,
  input  logic signed [23:0] angle_deg_i,
  output logic               valid_o,
  input  logic               stall_i,
  output logic signed [15:0] m00_o,
  output logic signed [15:0] m01_o,
  output logic signed [15:0] m02_o,
  output logic signed [15:0] m10_o,
  output logic signed [15:0] m11_o,
  output logic signed [15:0] m12_o,
  output logic signed [15:0] m20_o,
  output logic signed [15:0] m21_o,
  output logic signed [15:0] m22_o,
  output logic               zero_axis_o
);

  localparam int NT = aarm_pkg::TOTAL_LAT;
  localparam logic [15:0] ID_CODE = 16'(64'd1 << OUT_FRAC_BITS);

  logic          en;
  logic [NT-1:0] vld_q;

  assign stall_o = vld_q[NT-1] && stall_i;
  assign en      = !stall_o;
  assign valid_o = vld_q[NT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NT-2:0], valid_i};
    end
  end

  logic signed [31:0] sin_w, ux_w, uy_w, uz_w;
  logic signed [32:0] omc_w;
  logic               nz_w;
  logic [8:0][15:0]   m_w;

  aarm_angle u_angle (
    .clk_i (clk_i),
    .en_i  (en),
    .ang_i (angle_deg_i),
    .sin_o (sin_w),
    .omc_o (omc_w)
  );

  aarm_norm u_norm (
    .clk_i  (clk_i),
    .en_i   (en),
    .ax_i   (axis_x_i),
    .ay_i   (axis_y_i),
    .az_i   (axis_z_i),
    .ux_o   (ux_w),
    .uy_o   (uy_w),
    .uz_o   (uz_w),
    .zero_o (nz_w)
  );

  aarm_matrix #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_matrix (
    .clk_i  (clk_i),
    .en_i   (en),
    .ux_i   (ux_w),
    .uy_i   (uy_w),
    .uz_i   (uz_w),
    .sin_i  (sin_w),
    .omc_i  (omc_w),
    .zero_i (nz_w),
    .m_o    (m_w),
    .zero_o (zero_axis_o)
  );

  assign m00_o = $signed(m_w[0]);
  assign m01_o = $signed(m_w[1]);
  assign m02_o = $signed(m_w[2]);
  assign m10_o = $signed(m_w[3]);
  assign m11_o = $signed(m_w[4]);
  assign m12_o = $signed(m_w[5]);
  assign m20_o = $signed(m_w[6]);
  assign m21_o = $signed(m_w[7]);
  assign m22_o = $signed(m_w[8]);

  a_stall_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> valid_o)
    else $error("stall raised with no result waiting");

  a_accept_enters_pipe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !stall_o |=> vld_q[0])
    else $error("accepted word missing from first stage");

  a_zero_axis_identity : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && zero_axis_o |-> (m00_o == ID_CODE) && (m11_o == ID_CODE) &&
                               (m22_o == ID_CODE) && (m01_o == 16'sd0) &&
                               (m12_o == 16'sd0))
    else $error("zero axis did not give identity");

endmodule

`default_nettype wire
